// ===== hdl/dnsw_pkg.sv =====
// Shared constants, codes and a helper function for the DNS wildcard responder.
package dnsw_pkg;

    // Default packet buffer size in bytes.
    localparam int MAX_PACKET_DEF = 512;

    // Question names of this many bytes or more are not answered.
    localparam int MAX_NAME = 255;

    // Fixed DNS header length and reply size limits.
    localparam int HDR_LEN   = 12;
    localparam int MAX_WORDS = 64;
    localparam int REPLY_CAP = MAX_WORDS * 8;

    // Answer length beyond the question name: header, terminator, question type and class, and answer record.
    localparam int ANSWER_EXTRA = HDR_LEN + 1 + 20;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESOLVED_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_ENABLE    = 1'b1;

    // Register reset values.
    localparam logic [31:0] RESOLVED_ADDRESS_RST = 32'hC0A8_0101;

    // Reply kinds.
    localparam logic KIND_ANSWER  = 1'b0;
    localparam logic KIND_REFUSED = 1'b1;

    // Fixed reply bytes.
    localparam logic [7:0] ANSWER_FLAGS_HI = 8'h85;
    localparam logic [7:0] ANSWER_FLAGS_LO = 8'h80;
    localparam logic [7:0] QR_BIT          = 8'h80;
    localparam logic [7:0] RCODE_REFUSED   = 8'h05;
    localparam logic [7:0] NAME_PTR_HI     = 8'hC0;
    localparam logic [7:0] NAME_PTR_LO     = 8'h0C;
    localparam logic [7:0] ANSWER_TTL      = 8'd60;
    localparam logic [7:0] RDATA_LEN       = 8'd4;

    // Byte t of the 20-byte tail that follows the question name in an answer:
    // type A, class IN, name pointer, type A, class IN, TTL, length, address.
    function automatic logic [7:0] tail_byte(input logic [4:0] t, input logic [31:0] addr);
        logic [7:0] b;
        b = 8'h00;
        case (t) inside
            5'd1, 5'd3, 5'd7, 5'd9: b = 8'h01;
            5'd4:                   b = NAME_PTR_HI;
            5'd5:                   b = NAME_PTR_LO;
            5'd13:                  b = ANSWER_TTL;
            5'd15:                  b = RDATA_LEN;
            5'd16:                  b = addr[31:24];
            5'd17:                  b = addr[23:16];
            5'd18:                  b = addr[15:8];
            5'd19:                  b = addr[7:0];
            default:                b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/dnsw_if.sv =====
// Channel interfaces of the DNS wildcard responder: query bytes, reply words, configuration.

// Query channel: one payload byte per word.
interface dnsw_query_if;
    logic        valid;
    logic        ready;
    logic [7:0]  packet_byte;
    logic        last_byte;
    logic [31:0] requester_address;
    logic [15:0] requester_port;

    modport source (output valid, packet_byte, last_byte, requester_address,
                    requester_port, input ready);
    modport sink   (input valid, packet_byte, last_byte, requester_address,
                    requester_port, output ready);
endinterface

// Reply channel: up to eight reply bytes per word.
interface dnsw_reply_if;
    logic        valid;
    logic        ready;
    logic [63:0] reply_word;
    logic [3:0]  valid_bytes;
    logic        last_word;
    logic        reply_kind;
    logic [31:0] reply_address;
    logic [15:0] reply_port;

    modport source (output valid, reply_word, valid_bytes, last_word, reply_kind,
                    reply_address, reply_port, input ready);
    modport sink   (input valid, reply_word, valid_bytes, last_word, reply_kind,
                    reply_address, reply_port, output ready);
endinterface

// Configuration write channel.
interface dnsw_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dnsw_pkg::CFG_IDX_W-1:0] index;
    logic [31:0]                    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/dns_wildcard_responder.sv =====
// DNS wildcard responder: buffers a query, then answers, refuses or drops it.
//
// Query bytes are accepted one per cycle into a packet memory of MAX_PACKET bytes kept as
// 8-byte rows; the header check and the question-name scan run as the bytes arrive. In the
// cycle after the final byte the block decides on the reply, then drains it as 8-byte words,
// each loaded in S_LOAD and held in S_SEND until the sink takes it, because each word is
// built from one registered read of the packet memory. No query byte is accepted from the
// final byte until the last reply word is taken (or, for a dropped packet, while the
// decision is made). Answers carry the configured address; other queries are echoed with
// QR set and rcode 5; short, oversize, malformed and disabled cases send nothing.
module dns_wildcard_responder #(
    parameter int MAX_PACKET = dnsw_pkg::MAX_PACKET_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    dnsw_query_if.sink   i_query,
    dnsw_reply_if.source o_reply,
    dnsw_cfg_if.sink     i_cfg
);

    localparam int CNT_W = $clog2(MAX_PACKET + 1);
    localparam int ROWS  = (MAX_PACKET + 7) / 8;
    localparam int ROW_W = $clog2(ROWS);
    localparam int LW    = (CNT_W > 10) ? CNT_W : 10;
    localparam int WIDX  = (ROW_W > 6) ? ROW_W : 6;

    localparam logic [1:0] S_RECV   = 2'd0;
    localparam logic [1:0] S_DECIDE = 2'd1;
    localparam logic [1:0] S_LOAD   = 2'd2;
    localparam logic [1:0] S_SEND   = 2'd3;

    // Configuration registers.
    logic [31:0] r_resolved;
    logic        r_enable;

    // Receive side state.
    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count;
    logic             r_over;
    logic             r_hdr_bad;
    logic [7:0]       r_nl;
    logic             r_scan_done;
    logic [31:0]      r_held_addr;
    logic [15:0]      r_held_port;

    // Reply side state.
    logic [5:0]  r_word;
    logic [9:0]  r_left;
    logic [8:0]  r_name_end;
    logic        r_kind;
    logic        r_out_valid;
    logic [63:0] r_out_word;
    logic [3:0]  r_out_bytes;
    logic        r_out_last;

    // Packet memory and its registered read data.
    logic [63:0]      r_mem [ROWS];
    logic [63:0]      r_rd;
    logic [ROW_W-1:0] wr_row;
    logic [ROW_W-1:0] rd_row;
    logic [WIDX-1:0]  rd_row_wide;
    logic [2:0]       wr_lane;

    logic q_acc, out_acc, cfg_acc, store_en;

    // Decision signals.
    logic [LW-1:0] len_w;
    logic          n_reply;
    logic [9:0]    n_len;
    logic          n_kind;

    // Word formation signals.
    logic [3:0]  lane_cnt;
    logic        word_last;
    logic [63:0] n_out_word;

    assign q_acc   = i_query.valid && i_query.ready;
    assign out_acc = o_reply.valid && o_reply.ready;
    assign cfg_acc = i_cfg.valid && i_cfg.ready;
    assign store_en = q_acc && (r_count < CNT_W'(MAX_PACKET));

    assign i_query.ready = (r_state == S_RECV);
    assign i_cfg.ready   = 1'b1;

    assign o_reply.valid         = r_out_valid;
    assign o_reply.reply_word    = r_out_word;
    assign o_reply.valid_bytes   = r_out_bytes;
    assign o_reply.last_word     = r_out_last;
    assign o_reply.reply_kind    = r_kind;
    assign o_reply.reply_address = r_held_addr;
    assign o_reply.reply_port    = r_held_port;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resolved <= dnsw_pkg::RESOLVED_ADDRESS_RST;
            r_enable   <= 1'b0;
        end else if (cfg_acc) begin
            unique case (i_cfg.index)
                dnsw_pkg::CFG_RESOLVED_ADDRESS: r_resolved <= i_cfg.data;
                dnsw_pkg::CFG_SERVER_ENABLE:    r_enable   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // Packet memory: byte-lane writes while receiving, one row read per cycle.
    assign wr_row      = ROW_W'(r_count[CNT_W-1:3]);
    assign wr_lane     = r_count[2:0];
    assign rd_row_wide = WIDX'(r_word);
    assign rd_row      = rd_row_wide[ROW_W-1:0];

    always_ff @(posedge i_clk) begin
        if (store_en) begin
            r_mem[wr_row][(7 - wr_lane) * 8 +: 8] <= i_query.packet_byte;
        end
        r_rd <= r_mem[rd_row];
    end

    // Reply decision from the state left by the final byte.
    always_comb begin
        len_w   = LW'(r_count);
        n_reply = 1'b0;
        n_len   = 10'd0;
        n_kind  = dnsw_pkg::KIND_REFUSED;
        if (r_enable && !r_over && len_w >= LW'(dnsw_pkg::HDR_LEN)) begin
            if (!r_hdr_bad) begin
                n_kind = dnsw_pkg::KIND_ANSWER;
                if (r_nl < 8'(dnsw_pkg::MAX_NAME) &&
                    LW'(r_nl) + LW'(dnsw_pkg::HDR_LEN + 4) < len_w) begin
                    n_reply = 1'b1;
                    n_len   = 10'(r_nl) + 10'(dnsw_pkg::ANSWER_EXTRA);
                end
            end else begin
                n_reply = 1'b1;
                if (len_w > LW'(dnsw_pkg::REPLY_CAP)) begin
                    n_len = 10'(dnsw_pkg::REPLY_CAP);
                end else begin
                    n_len = len_w[9:0];
                end
            end
        end
    end

    // Build one reply word from the fetched row, fixed header bytes and the answer tail.
    always_comb begin
        logic [8:0] p;
        logic [7:0] mb;
        logic [7:0] b;
        lane_cnt   = (r_left > 10'd8) ? 4'd8 : r_left[3:0];
        word_last  = (r_left <= 10'd8);
        n_out_word = 64'd0;
        for (int j = 0; j < 8; j++) begin
            p  = {r_word, 3'(j)};
            mb = r_rd[(7 - j) * 8 +: 8];
            b  = mb;
            if (r_kind == dnsw_pkg::KIND_REFUSED) begin
                if (p == 9'd2) begin
                    b = mb | dnsw_pkg::QR_BIT;
                end else if (p == 9'd3) begin
                    b = dnsw_pkg::RCODE_REFUSED;
                end
            end else if (p < 9'd2) begin
                b = mb;
            end else if (p < 9'(dnsw_pkg::HDR_LEN)) begin
                if (p == 9'd2) begin
                    b = dnsw_pkg::ANSWER_FLAGS_HI;
                end else if (p == 9'd3) begin
                    b = dnsw_pkg::ANSWER_FLAGS_LO;
                end else if (p == 9'd5 || p == 9'd7) begin
                    b = 8'h01;
                end else begin
                    b = 8'h00;
                end
            end else if (p < r_name_end) begin
                b = mb;
            end else begin
                b = dnsw_pkg::tail_byte(5'(p - r_name_end), r_resolved);
            end
            if (4'(j) >= lane_cnt) begin
                b = 8'h00;
            end
            n_out_word[(7 - j) * 8 +: 8] = b;
        end
    end

    // Sequencer: receive, decide, then alternate loading and sending, or skip to receive.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RECV:   if (q_acc && i_query.last_byte) n_state = S_DECIDE;
            S_DECIDE: n_state = n_reply ? S_LOAD : S_RECV;
            S_LOAD:   n_state = S_SEND;
            S_SEND:   if (out_acc) n_state = r_out_last ? S_RECV : S_LOAD;
            default:  n_state = S_RECV;
        endcase
    end

    // Receive bookkeeping and reply drain control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RECV;
            r_count     <= '0;
            r_over      <= 1'b0;
            r_hdr_bad   <= 1'b0;
            r_nl        <= 8'd0;
            r_scan_done <= 1'b0;
            r_held_addr <= 32'd0;
            r_held_port <= 16'd0;
            r_word      <= 6'd0;
            r_left      <= 10'd0;
            r_out_valid <= 1'b0;
            r_kind      <= dnsw_pkg::KIND_ANSWER;
        end else begin
            r_state <= n_state;

            // Sample the requester on the first byte of a packet.
            if (q_acc && r_count == '0 && !r_over) begin
                r_held_addr <= i_query.requester_address;
                r_held_port <= i_query.requester_port;
            end

            // Count stored bytes, check the QD, AN and NS count fields and scan the question name.
            if (q_acc && !store_en) begin
                r_over <= 1'b1;
            end
            if (store_en) begin
                r_count <= r_count + CNT_W'(1);
                if (r_count >= CNT_W'(4) && r_count <= CNT_W'(9) &&
                    i_query.packet_byte != ((r_count == CNT_W'(5)) ? 8'h01 : 8'h00)) begin
                    r_hdr_bad <= 1'b1;
                end
                if (r_count >= CNT_W'(dnsw_pkg::HDR_LEN) && !r_scan_done) begin
                    if (i_query.packet_byte == 8'h00) begin
                        r_scan_done <= 1'b1;
                    end else begin
                        r_nl <= r_nl + 8'd1;
                        if (r_nl + 8'd1 == 8'(dnsw_pkg::MAX_NAME)) begin
                            r_scan_done <= 1'b1;
                        end
                    end
                end
            end

            // Latch the decision and clear the receiver for the next packet.
            if (r_state == S_DECIDE) begin
                r_left      <= n_len;
                r_kind      <= n_kind;
                r_name_end  <= 9'(r_nl) + 9'(dnsw_pkg::HDR_LEN + 1);
                r_count     <= '0;
                r_over      <= 1'b0;
                r_hdr_bad   <= 1'b0;
                r_nl        <= 8'd0;
                r_scan_done <= 1'b0;
            end

            // Load one word into the output register and advance to the next row.
            if (r_state == S_LOAD) begin
                r_out_word  <= n_out_word;
                r_out_bytes <= lane_cnt;
                r_out_last  <= word_last;
                r_out_valid <= 1'b1;
                r_word      <= r_word + 6'd1;
                if (!word_last) begin
                    r_left <= r_left - 10'd8;
                end
            end

            // Hand the word over; the last one rewinds the row index for the next packet.
            if (r_state == S_SEND && out_acc) begin
                r_out_valid <= 1'b0;
                if (r_out_last) begin
                    r_word <= 6'd0;
                end
            end
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the DNS wildcard responder: query stimulus, reply prediction, checks.
`timescale 1ns / 100ps

module testbench;

    localparam int PACKET_BYTES  = dnsw_pkg::MAX_PACKET_DEF;
    localparam int IDLE_PERCENT  = 38;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 170;
    localparam int RANDOM_WORDS  = 40;
    localparam int CYCLE_LIMIT   = 400000;

    // One reply word as the block should send it.
    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
        logic        kind;
        logic [31:0] addr;
        logic [15:0] port;
    } t_reply_word;

    logic i_clk = 1'b0;
    logic i_rst_n;

    dnsw_query_if query_bus ();
    dnsw_reply_if reply_bus ();
    dnsw_cfg_if   cfg_bus ();

    dns_wildcard_responder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_query (query_bus),
        .o_reply (reply_bus),
        .i_cfg   (cfg_bus)
    );

    // Free-running clock, 10 ns period.
    always #5 i_clk = ~i_clk;

    // Shadow copy of the responder's registers and receive state.
    logic [7:0]  stored_query [PACKET_BYTES];
    int unsigned stored_len   = 0;
    logic        oversize     = 1'b0;
    logic [31:0] held_addr    = '0;
    logic [15:0] held_port    = '0;
    logic [31:0] resp_address = dnsw_pkg::RESOLVED_ADDRESS_RST;
    logic        resp_enable  = 1'b0;

    t_reply_word pending_words [$];
    logic [7:0]  query_buf [$];

    bit          idle_on         = 1'b1;
    int unsigned mismatches      = 0;
    int unsigned cycle_count     = 0;
    int unsigned bytes_sent      = 0;
    int unsigned packets_sent    = 0;
    int unsigned words_predicted = 0;
    int unsigned words_checked   = 0;
    int unsigned answered        = 0;
    int unsigned refused         = 0;
    int unsigned dropped         = 0;

    // Track one accepted query byte; at the final byte, queue the reply words it causes.
    task automatic absorb_query_byte(input logic [7:0] qbyte, input logic qlast,
                                     input logic [31:0] qaddr, input logic [15:0] qport);
        logic [7:0]   reply_bytes [dnsw_pkg::REPLY_CAP];
        logic [159:0] tail;
        t_reply_word  rw;
        int unsigned  rlen, name_len, pos, nwords, nvalid, k, j;
        logic         rkind;
        if (stored_len == 0 && !oversize) begin
            held_addr = qaddr;
            held_port = qport;
        end
        if (stored_len < PACKET_BYTES) begin
            stored_query[stored_len] = qbyte;
            stored_len++;
        end else begin
            oversize = 1'b1;
        end
        if (!qlast) return;

        rlen  = 0;
        rkind = dnsw_pkg::KIND_ANSWER;
        if (!oversize && resp_enable && stored_len >= dnsw_pkg::HDR_LEN) begin
            if (stored_query[4] == 8'h00 && stored_query[5] == 8'h01 &&
                stored_query[6] == 8'h00 && stored_query[7] == 8'h00 &&
                stored_query[8] == 8'h00 && stored_query[9] == 8'h00) begin
                // Single plain question: find the name terminator within the name limit.
                pos      = dnsw_pkg::HDR_LEN;
                name_len = 0;
                while (pos < stored_len && stored_query[pos] != 8'h00 &&
                       name_len < dnsw_pkg::MAX_NAME) begin
                    name_len++;
                    pos++;
                end
                if (name_len < dnsw_pkg::MAX_NAME && pos + 4 < stored_len) begin
                    for (k = 0; k < dnsw_pkg::HDR_LEN; k++) reply_bytes[k] = 8'h00;
                    reply_bytes[0] = stored_query[0];
                    reply_bytes[1] = stored_query[1];
                    reply_bytes[2] = dnsw_pkg::ANSWER_FLAGS_HI;
                    reply_bytes[3] = dnsw_pkg::ANSWER_FLAGS_LO;
                    reply_bytes[5] = 8'h01;
                    reply_bytes[7] = 8'h01;
                    rlen = dnsw_pkg::HDR_LEN;
                    for (k = 0; k <= name_len; k++) begin
                        reply_bytes[rlen] = stored_query[dnsw_pkg::HDR_LEN + k];
                        rlen++;
                    end
                    // Type A, class IN, name pointer, type A, class IN, TTL, length, address.
                    tail = {16'h0001, 16'h0001, dnsw_pkg::NAME_PTR_HI, dnsw_pkg::NAME_PTR_LO,
                            16'h0001, 16'h0001, 24'h000000, dnsw_pkg::ANSWER_TTL, 8'h00,
                            dnsw_pkg::RDATA_LEN, resp_address};
                    for (k = 0; k < 20; k++) begin
                        reply_bytes[rlen] = tail[159 - 8 * k -: 8];
                        rlen++;
                    end
                end
            end else begin
                // Anything else is echoed back as a refusal.
                for (k = 0; k < stored_len; k++) reply_bytes[k] = stored_query[k];
                reply_bytes[2] = reply_bytes[2] | dnsw_pkg::QR_BIT;
                reply_bytes[3] = dnsw_pkg::RCODE_REFUSED;
                rlen  = stored_len;
                rkind = dnsw_pkg::KIND_REFUSED;
            end
        end

        // Pack the reply into 8-byte words, first byte at the top.
        nwords = (rlen + 7) / 8;
        if (nwords > dnsw_pkg::MAX_WORDS) nwords = dnsw_pkg::MAX_WORDS;
        for (k = 0; k < nwords; k++) begin
            nvalid  = (rlen - 8 * k < 8) ? rlen - 8 * k : 8;
            rw.word = '0;
            for (j = 0; j < 8; j++)
                rw.word = {rw.word[55:0], (j < nvalid) ? reply_bytes[8 * k + j] : 8'h00};
            rw.nbytes = 4'(nvalid);
            rw.last   = (k + 1 == nwords);
            rw.kind   = rkind;
            rw.addr   = held_addr;
            rw.port   = held_port;
            pending_words.push_back(rw);
            words_predicted++;
        end
        if (nwords == 0) dropped++;
        else if (rkind == dnsw_pkg::KIND_ANSWER) answered++;
        else refused++;
        stored_len = 0;
        oversize   = 1'b0;
    endtask

    // Wait until every predicted word has arrived, then let the block settle.
    task automatic wait_for_replies();
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one configuration register while the block is idle.
    task automatic write_reg(input logic [dnsw_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        wait_for_replies();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        if (idx == dnsw_pkg::CFG_RESOLVED_ADDRESS) resp_address = value;
        else resp_enable = value[0];
        cfg_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one query byte, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_byte(input logic [7:0] qbyte, input logic qlast,
                             input logic [31:0] qaddr, input logic [15:0] qport);
        while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
            query_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        query_bus.valid             <= 1'b1;
        query_bus.packet_byte       <= qbyte;
        query_bus.last_byte         <= qlast;
        query_bus.requester_address <= qaddr;
        query_bus.requester_port    <= qport;
        @(posedge i_clk);
        while (!query_bus.ready) @(posedge i_clk);
        bytes_sent++;
        absorb_query_byte(qbyte, qlast, qaddr, qport);
    endtask

    // Send the assembled packet; the requester fields only matter on the first byte.
    task automatic send_query(input logic [31:0] qaddr, input logic [15:0] qport);
        int unsigned k;
        for (k = 0; k < query_buf.size(); k++) begin
            if (k == 0) send_byte(query_buf[k], k + 1 == query_buf.size(), qaddr, qport);
            else send_byte(query_buf[k], k + 1 == query_buf.size(), $urandom, 16'($urandom));
        end
        query_bus.valid <= 1'b0;
        @(posedge i_clk);
        query_buf.delete();
        packets_sent++;
    endtask

    task automatic put_header(input logic [15:0] id, input logic [15:0] flags,
                              input logic [15:0] qd, input logic [15:0] an,
                              input logic [15:0] ns, input logic [15:0] ar);
        query_buf.push_back(id[15:8]);
        query_buf.push_back(id[7:0]);
        query_buf.push_back(flags[15:8]);
        query_buf.push_back(flags[7:0]);
        query_buf.push_back(qd[15:8]);
        query_buf.push_back(qd[7:0]);
        query_buf.push_back(an[15:8]);
        query_buf.push_back(an[7:0]);
        query_buf.push_back(ns[15:8]);
        query_buf.push_back(ns[7:0]);
        query_buf.push_back(ar[15:8]);
        query_buf.push_back(ar[7:0]);
    endtask

    task automatic put_random(input int unsigned count, input int unsigned lo,
                              input int unsigned hi);
        int unsigned k;
        for (k = 0; k < count; k++) query_buf.push_back(8'($urandom_range(hi, lo)));
    endtask

    // One random packet: mostly well-formed questions, some broken ones, some noise.
    task automatic send_random_query();
        int unsigned shape, labels, llen, k;
        shape = $urandom_range(99);
        if (shape < 65) begin
            put_header(16'($urandom), 16'($urandom), 16'h0001, 16'h0000, 16'h0000,
                       16'($urandom));
            labels = $urandom_range(3);
            for (k = 0; k < labels; k++) begin
                llen = $urandom_range(14, 1);
                query_buf.push_back(8'(llen));
                put_random(llen, 1, 255);
            end
            query_buf.push_back(8'h00);
            put_random(4 + ($urandom_range(99) < 30 ? $urandom_range(6) : 0), 0, 255);
        end else if (shape < 80) begin
            put_header(16'($urandom), 16'($urandom), 16'h0001, 16'h0000, 16'h0000,
                       16'($urandom));
            put_random($urandom_range(20), 1, 255);
            if ($urandom_range(1) == 1) begin
                query_buf.push_back(8'h00);
                put_random($urandom_range(3), 0, 255);
            end
        end else begin
            put_random($urandom_range(40, 1), 0, 255);
        end
        send_query($urandom, 16'($urandom));
    endtask

    // A query is dropped while disabled; enabling answers it with the reset address.
    task automatic test_disabled_after_reset();
        int unsigned pass;
        for (pass = 0; pass < 2; pass++) begin
            put_header(16'h0000, 16'h0100, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
            query_buf.push_back(8'h03);
            query_buf.push_back(8'h61);
            query_buf.push_back(8'h62);
            query_buf.push_back(8'h63);
            query_buf.push_back(8'h00);
            put_random(4, 0, 1);
            send_query(32'h0000_0000, 16'h0000);
            if (pass == 0) write_reg(dnsw_pkg::CFG_SERVER_ENABLE, 32'd1);
        end
    endtask

    // Answers carry the lowest and highest configured addresses.
    task automatic test_address_extremes();
        write_reg(dnsw_pkg::CFG_RESOLVED_ADDRESS, 32'h0000_0000);
        put_header(16'hFFFF, 16'hFFFF, 16'h0001, 16'h0000, 16'h0000, 16'hFFFF);
        query_buf.push_back(8'h02);
        put_random(2, 255, 255);
        query_buf.push_back(8'h00);
        put_random(4, 255, 255);
        send_query(32'hFFFF_FFFF, 16'hFFFF);
        write_reg(dnsw_pkg::CFG_RESOLVED_ADDRESS, 32'hFFFF_FFFF);
        // Root name: the terminator comes right after the header.
        put_header(16'h1234, 16'h0000, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        query_buf.push_back(8'h00);
        put_random(4, 0, 255);
        send_query(32'h8000_0001, 16'h8001);
    endtask

    // Packets shorter than a header, and a bare header, give nothing; a bare header
    // that is not a plain question is still refused.
    task automatic test_short_packets();
        put_random(1, 255, 255);
        send_query($urandom, 16'($urandom));
        put_random(11, 0, 255);
        send_query($urandom, 16'($urandom));
        put_header(16'($urandom), 16'h0100, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        send_query($urandom, 16'($urandom));
        put_header(16'($urandom), 16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_query($urandom, 16'($urandom));
    endtask

    // Question name bounds: missing terminator, too few bytes after it, longest names.
    task automatic test_name_bounds();
        put_header(16'($urandom), 16'h0100, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        put_random(5, 1, 255);
        query_buf.push_back(8'h00);
        put_random(3, 0, 255);
        send_query($urandom, 16'($urandom));
        put_header(16'($urandom), 16'h0100, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        put_random(9, 1, 255);
        send_query($urandom, 16'($urandom));
        put_header(16'($urandom), 16'h0100, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        put_random(dnsw_pkg::MAX_NAME - 1, 1, 255);
        query_buf.push_back(8'h00);
        put_random(4, 0, 255);
        send_query($urandom, 16'($urandom));
        put_header(16'($urandom), 16'h0100, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        put_random(dnsw_pkg::MAX_NAME, 1, 255);
        query_buf.push_back(8'h00);
        put_random(4, 0, 255);
        send_query($urandom, 16'($urandom));
    endtask

    // Headers that are not one plain question are refused; the extra count is ignored.
    task automatic test_refusals();
        put_header(16'($urandom), 16'hFFFF, 16'h0002, 16'h0000, 16'h0000, 16'h0000);
        put_random(9, 0, 255);
        send_query($urandom, 16'($urandom));
        put_header(16'($urandom), 16'h0000, 16'h0001, 16'h0001, 16'h0000, 16'h0000);
        put_random(6, 0, 255);
        send_query($urandom, 16'($urandom));
        put_header(16'($urandom), 16'h8005, 16'h0001, 16'h0000, 16'h0100, 16'h0000);
        put_random(3, 0, 255);
        send_query($urandom, 16'($urandom));
        put_header(16'($urandom), 16'h0100, 16'h0101, 16'h0000, 16'h0000, 16'h0000);
        send_query($urandom, 16'($urandom));
        // A refusal is dropped too while the block is disabled.
        write_reg(dnsw_pkg::CFG_SERVER_ENABLE, 32'd0);
        put_header(16'($urandom), 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        put_random(8, 0, 255);
        send_query($urandom, 16'($urandom));
        write_reg(dnsw_pkg::CFG_SERVER_ENABLE, 32'd1);
    endtask

    // Full buffer echoed as the longest reply; one byte more and the packet is dropped.
    task automatic test_packet_size_limits();
        put_header(16'($urandom), 16'h7F00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        put_random(PACKET_BYTES - dnsw_pkg::HDR_LEN, 0, 255);
        send_query($urandom, 16'($urandom));
        put_header(16'($urandom), 16'h7F00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        put_random(PACKET_BYTES - dnsw_pkg::HDR_LEN + 1, 0, 255);
        send_query($urandom, 16'($urandom));
        put_header(16'($urandom), 16'h0100, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        query_buf.push_back(8'h00);
        put_random(PACKET_BYTES + 80, 0, 255);
        send_query($urandom, 16'($urandom));
        // The receiver must recover after an oversize packet.
        put_header(16'($urandom), 16'h0100, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
        query_buf.push_back(8'h01);
        put_random(1, 1, 255);
        query_buf.push_back(8'h00);
        put_random(4, 0, 255);
        send_query($urandom, 16'($urandom));
    endtask

    // Both channels run with no random idle cycles.
    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (8) send_random_query();
        wait_for_replies();
        idle_on = 1'b1;
    endtask

    // Random packets, with occasional new settings in between.
    task automatic test_random_traffic();
        int unsigned start_bytes, start_words;
        start_bytes = bytes_sent;
        start_words = words_predicted;
        while (bytes_sent - start_bytes < RANDOM_ITEMS ||
               words_predicted - start_words < RANDOM_WORDS) begin
            if ($urandom_range(99) < 12) begin
                write_reg(dnsw_pkg::CFG_RESOLVED_ADDRESS, $urandom);
                write_reg(dnsw_pkg::CFG_SERVER_ENABLE, {31'd0, $urandom_range(99) < 80});
            end
            send_random_query();
        end
    endtask

    task automatic check_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            mismatches++;
        end
    endtask

    // Reply sink: compare each accepted word with the oldest prediction, then stall at random.
    always @(posedge i_clk) begin : reply_monitor
        t_reply_word want;
        if (i_rst_n === 1'b1 && reply_bus.valid === 1'b1 && reply_bus.ready === 1'b1) begin
            if (pending_words.size() == 0) begin
                $error("reply word %0h arrived with no reply pending", reply_bus.reply_word);
                mismatches++;
            end else begin
                want = pending_words.pop_front();
                check_field("reply_word", want.word, reply_bus.reply_word);
                check_field("valid_bytes", 64'(want.nbytes), 64'(reply_bus.valid_bytes));
                check_field("last_word", 64'(want.last), 64'(reply_bus.last_word));
                check_field("reply_kind", 64'(want.kind), 64'(reply_bus.reply_kind));
                check_field("reply_address", 64'(want.addr), 64'(reply_bus.reply_address));
                check_field("reply_port", 64'(want.port), 64'(reply_bus.reply_port));
                words_checked++;
            end
        end
        reply_bus.ready <= !(idle_on && $urandom_range(99) < IDLE_PERCENT);
    end

    // Watchdog on the whole run.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("testbench failed");
        $finish;
    end

    initial begin
        i_rst_n                     <= 1'b0;
        query_bus.valid             <= 1'b0;
        query_bus.packet_byte       <= 8'h00;
        query_bus.last_byte         <= 1'b0;
        query_bus.requester_address <= 32'h0;
        query_bus.requester_port    <= 16'h0;
        cfg_bus.valid               <= 1'b0;
        cfg_bus.index               <= dnsw_pkg::CFG_RESOLVED_ADDRESS;
        cfg_bus.data                <= 32'h0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_disabled_after_reset();
        test_address_extremes();
        test_short_packets();
        test_name_bounds();
        test_refusals();
        test_packet_size_limits();
        test_back_to_back();
        test_random_traffic();
        wait_for_replies();

        $display("Sent %0d query packets (%0d bytes): %0d answered, %0d refused, %0d dropped.",
                 packets_sent, bytes_sent, answered, refused, dropped);
        $display("Compared %0d reply words field by field.", words_checked);
        if (mismatches == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/dnsw_pkg.sv
hdl/dnsw_if.sv
hdl/dns_wildcard_responder.sv
tb/sv/testbench.sv
